### rtl/core/e2q_pkg.sv
package e2q_pkg;

  localparam int ANGLE_WIDTH  = 16;
  localparam int QUAT_WIDTH   = 16;
  localparam int CORDIC_STEPS = 24;

  // CORDIC datapath widths: x/y hold values near +-1.0 in Q.30, z holds +-pi/2
  localparam int XY_WIDTH   = 34;
  localparam int Z_WIDTH    = 33;
  localparam int FOLD_WIDTH = 35;
  localparam int TRIG_WIDTH = 32;
  localparam int SUM_WIDTH  = 34;

  localparam int QUAT_SHIFT = 30 - (QUAT_WIDTH - 1);

  localparam logic signed [FOLD_WIDTH-1:0] Q30_HALF_PI = 35'sd1686629713;
  localparam logic signed [FOLD_WIDTH-1:0] Q30_PI      = 35'sd3373259426;
  localparam logic signed [XY_WIDTH-1:0]   CORDIC_GAIN = 34'sd652032874;

  // pipeline depth: fold register, one register per CORDIC step, two product stages, output
  localparam int PIPE_DEPTH = CORDIC_STEPS + 4;

  typedef logic signed [TRIG_WIDTH-1:0] trig_t;
  typedef logic signed [ANGLE_WIDTH-1:0] angle_t;
  typedef logic signed [QUAT_WIDTH-1:0] quat_t;

  function automatic logic signed [Z_WIDTH-1:0] atan_q30(input int step);
    logic signed [Z_WIDTH-1:0] r;
    case (step)
      0:       r = 33'sd843314856;
      1:       r = 33'sd497837829;
      2:       r = 33'sd263043836;
      3:       r = 33'sd133525158;
      4:       r = 33'sd67021686;
      5:       r = 33'sd33543515;
      6:       r = 33'sd16775850;
      7:       r = 33'sd8388437;
      8:       r = 33'sd4194282;
      9:       r = 33'sd2097149;
      10:      r = 33'sd1048575;
      11:      r = 33'sd524287;
      12:      r = 33'sd262143;
      13:      r = 33'sd131071;
      14:      r = 33'sd65535;
      15:      r = 33'sd32767;
      16:      r = 33'sd16383;
      17:      r = 33'sd8191;
      18:      r = 33'sd4095;
      19:      r = 33'sd2047;
      20:      r = 33'sd1024;
      21:      r = 33'sd511;
      22:      r = 33'sd255;
      23:      r = 33'sd127;
      default: r = '0;
    endcase
    return r;
  endfunction

  // Q.30 product, round half up
  function automatic trig_t mul_q30(input trig_t a, input trig_t b);
    logic signed [2*TRIG_WIDTH-1:0] p;
    p = (2*TRIG_WIDTH)'(a) * (2*TRIG_WIDTH)'(b);
    p = p + (2*TRIG_WIDTH)'(64'sd536870912);
    p = p >>> 30;
    return p[TRIG_WIDTH-1:0];
  endfunction

  // Q.30 sum to Q1.(QUAT_WIDTH-1), round half up and saturate
  function automatic quat_t to_quat(input logic signed [SUM_WIDTH-1:0] v);
    logic signed [SUM_WIDTH:0] r;
    logic signed [SUM_WIDTH:0] hi;
    logic signed [SUM_WIDTH:0] lo;
    hi = (SUM_WIDTH+1)'((64'sd1 <<< (QUAT_WIDTH - 1)) - 64'sd1);
    lo = -hi - (SUM_WIDTH+1)'(1);
    r  = (SUM_WIDTH+1)'(v) + ((SUM_WIDTH+1)'(1) <<< (QUAT_SHIFT - 1));
    r  = r >>> QUAT_SHIFT;
    if (r > hi) r = hi;
    if (r < lo) r = lo;
    return r[QUAT_WIDTH-1:0];
  endfunction

endpackage

### rtl/core/e2q_cordic.sv
module e2q_cordic (
  input  logic                  clk_i,
  input  logic                  en_i,
  input  e2q_pkg::angle_t       angle_i,
  output e2q_pkg::trig_t        cos_o,
  output e2q_pkg::trig_t        sin_o
);
  import e2q_pkg::*;

  logic signed [XY_WIDTH-1:0] x_q [0:CORDIC_STEPS];
  logic signed [XY_WIDTH-1:0] y_q [0:CORDIC_STEPS];
  logic signed [Z_WIDTH-1:0]  z_q [0:CORDIC_STEPS];
  logic                       neg_q [0:CORDIC_STEPS];

  logic signed [FOLD_WIDTH-1:0] h;
  logic signed [FOLD_WIDTH-1:0] h_fold;
  logic                         neg_d;

  // half angle in Q.30, folded into +-pi/2
  always_comb begin
    h = FOLD_WIDTH'(angle_i) <<< (32 - ANGLE_WIDTH);
    h_fold = h;
    neg_d  = 1'b0;
    if (h > Q30_HALF_PI) begin
      h_fold = Q30_PI - h;
      neg_d  = 1'b1;
    end else if (h < -Q30_HALF_PI) begin
      h_fold = -Q30_PI - h;
      neg_d  = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q[0]   <= CORDIC_GAIN;
      y_q[0]   <= '0;
      z_q[0]   <= h_fold[Z_WIDTH-1:0];
      neg_q[0] <= neg_d;
    end
  end

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
    logic signed [XY_WIDTH-1:0] dx;
    logic signed [XY_WIDTH-1:0] dy;
    assign dx = y_q[i] >>> i;
    assign dy = x_q[i] >>> i;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        neg_q[i+1] <= neg_q[i];
        if (!z_q[i][Z_WIDTH-1]) begin
          x_q[i+1] <= x_q[i] - dx;
          y_q[i+1] <= y_q[i] + dy;
          z_q[i+1] <= z_q[i] - atan_q30(i);
        end else begin
          x_q[i+1] <= x_q[i] + dx;
          y_q[i+1] <= y_q[i] - dy;
          z_q[i+1] <= z_q[i] + atan_q30(i);
        end
      end
    end
  end

  logic signed [XY_WIDTH-1:0] x_out;
  assign x_out = neg_q[CORDIC_STEPS] ? -x_q[CORDIC_STEPS] : x_q[CORDIC_STEPS];
  assign cos_o = x_out[TRIG_WIDTH-1:0];
  assign sin_o = y_q[CORDIC_STEPS][TRIG_WIDTH-1:0];

endmodule

### rtl/core/e2q_mix.sv
module e2q_mix (
  input  logic             clk_i,
  input  logic             en_i,
  input  e2q_pkg::trig_t   cy_i,
  input  e2q_pkg::trig_t   sy_i,
  input  e2q_pkg::trig_t   cp_i,
  input  e2q_pkg::trig_t   sp_i,
  input  e2q_pkg::trig_t   cr_i,
  input  e2q_pkg::trig_t   sr_i,
  output e2q_pkg::quat_t   quat_w_o,
  output e2q_pkg::quat_t   quat_x_o,
  output e2q_pkg::quat_t   quat_y_o,
  output e2q_pkg::quat_t   quat_z_o
);
  import e2q_pkg::*;

  trig_t cc_q, ss_q, sc_q, cs_q, cy_q, sy_q;
  trig_t w0_q, w1_q, x0_q, x1_q, y0_q, y1_q, z0_q, z1_q;
  quat_t w_q, x_q, y_q, z_q;

  // roll/pitch pairs
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cc_q <= mul_q30(cr_i, cp_i);
      ss_q <= mul_q30(sr_i, sp_i);
      sc_q <= mul_q30(sr_i, cp_i);
      cs_q <= mul_q30(cr_i, sp_i);
      cy_q <= cy_i;
      sy_q <= sy_i;
    end
  end

  // times yaw
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      w0_q <= mul_q30(cc_q, cy_q);
      w1_q <= mul_q30(ss_q, sy_q);
      x0_q <= mul_q30(sc_q, cy_q);
      x1_q <= mul_q30(cs_q, sy_q);
      y0_q <= mul_q30(cs_q, cy_q);
      y1_q <= mul_q30(sc_q, sy_q);
      z0_q <= mul_q30(cc_q, sy_q);
      z1_q <= mul_q30(ss_q, cy_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      w_q <= to_quat(SUM_WIDTH'(w0_q) + SUM_WIDTH'(w1_q));
      x_q <= to_quat(SUM_WIDTH'(x0_q) - SUM_WIDTH'(x1_q));
      y_q <= to_quat(SUM_WIDTH'(y0_q) + SUM_WIDTH'(y1_q));
      z_q <= to_quat(SUM_WIDTH'(z0_q) - SUM_WIDTH'(z1_q));
    end
  end

  assign quat_w_o = w_q;
  assign quat_x_o = x_q;
  assign quat_y_o = y_q;
  assign quat_z_o = z_q;

endmodule

### rtl/core/euler_to_quaternion.sv
// Euler angles (ZYX order) to unit quaternion.
// Input channel: in_valid_i/in_ready_o with yaw, pitch and roll angles as
// signed Q3.13 radians. Any bit pattern is taken; angles beyond +-pi
// still give the correct rotation.
// Output channel: out_valid_o/out_ready_i with w, x, y, z as signed Q1.15;
// +1.0 saturates to the maximum code.
// The pipeline has one fold stage, 24 CORDIC step stages (three rotators
// side by side, one step per stage), two product stages and the output
// register. Throughput is one item per cycle unless the receiver stalls.
// The pipeline advances as a whole whenever the output register is empty
// or being taken; while the receiver stalls with a result waiting, every
// stage holds and in_ready_o is low, so nothing is lost or repeated.
// Reset clears all valid bits; the pipeline comes out of reset empty.
module euler_to_quaternion (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  e2q_pkg::angle_t     yaw_angle_i,
  input  e2q_pkg::angle_t     pitch_angle_i,
  input  e2q_pkg::angle_t     roll_angle_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output e2q_pkg::quat_t      quat_w_o,
  output e2q_pkg::quat_t      quat_x_o,
  output e2q_pkg::quat_t      quat_y_o,
  output e2q_pkg::quat_t      quat_z_o
);
  import e2q_pkg::*;

  logic  [PIPE_DEPTH-1:0] valid_q;
  logic                   en;
  trig_t cy, sy, cp, sp, cr, sr;

  assign en = !valid_q[PIPE_DEPTH-1] || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en) begin
      valid_q <= {valid_q[PIPE_DEPTH-2:0], in_valid_i};
    end
  end

  e2q_cordic u_yaw (
    .clk_i   (clk_i),
    .en_i    (en),
    .angle_i (yaw_angle_i),
    .cos_o   (cy),
    .sin_o   (sy)
  );

  e2q_cordic u_pitch (
    .clk_i   (clk_i),
    .en_i    (en),
    .angle_i (pitch_angle_i),
    .cos_o   (cp),
    .sin_o   (sp)
  );

  e2q_cordic u_roll (
    .clk_i   (clk_i),
    .en_i    (en),
    .angle_i (roll_angle_i),
    .cos_o   (cr),
    .sin_o   (sr)
  );

  e2q_mix u_mix (
    .clk_i    (clk_i),
    .en_i     (en),
    .cy_i     (cy),
    .sy_i     (sy),
    .cp_i     (cp),
    .sp_i     (sp),
    .cr_i     (cr),
    .sr_i     (sr),
    .quat_w_o (quat_w_o),
    .quat_x_o (quat_x_o),
    .quat_y_o (quat_y_o),
    .quat_z_o (quat_z_o)
  );

  assign in_ready_o  = en;
  assign out_valid_o = valid_q[PIPE_DEPTH-1];

endmodule
